>>> rtl/baro_temp_humidity_compensation_core_macros.svh
// Assertion macros for the compensation core checkers.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef BARO_TEMP_HUMIDITY_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_HUMIDITY_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTHC_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BTHC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/bthc_pkg.sv
// Shared types and constants for the compensation core.
// Used by bthc_div, the top level and the testbench; no dependencies.
package bthc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIXED_CAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_MID   = 3'd4;

  // Divider geometry: 64-bit dividend, divisor magnitude fits 31 bits
  localparam int QUO_W = 64;
  localparam int DVS_W = 31;

  // Humidity clamp before the final shift
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // Control bits that travel through the divider
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } div_ctl_t;

  // Finished results carried alongside the division
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
  } side_t;

endpackage

>>> rtl/baro_temp_humidity_compensation_core.sv
// Barometric / temperature / humidity integer compensation core.
// Depends on bthc_pkg and bthc_div.
// Input channel (in_valid/in_ready): one raw reading per transaction,
//   20-bit pressure, 20-bit temperature, 16-bit humidity.
// Output channel (out_valid/out_ready): one result per transaction:
//   temperature in 0.01 C, pressure in Pa (0 on a zero divisor),
//   humidity in 1/1024 %RH clamped to 0..102400.
// Configuration: cfg_we/cfg_index/cfg_wdata write the calibration words;
//   write them only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
//   From input acceptance to out_valid a result passes 12 arithmetic stages,
//   the 64-stage one-bit-per-stage divider and 4 post-division stages.
// Stall: when out_ready is low the pending result moves into a skid
//   register while the pipeline advances once more; after that in_ready
//   drops and the whole pipeline holds until the skid result is taken.
// Reset: synchronous, active low; clears all valid bits, including the skid
//   valid bit, and the calibration registers (all zero).
module baro_temp_humidity_compensation_core
  import bthc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [19:0]          in_raw_pressure,
  input  logic [19:0]          in_raw_temperature,
  input  logic [15:0]          in_raw_humidity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_temperature_centi,
  output logic [31:0]          out_pressure_pa,
  output logic [16:0]          out_humidity_q10,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  // ---------------- calibration registers ----------------
  logic [47:0] cal_temp_r;
  logic [63:0] cal_plo_r;
  logic [63:0] cal_phi_r;
  logic [55:0] cal_mix_r;
  logic [23:0] cal_hmid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r <= '0;
      cal_plo_r  <= '0;
      cal_phi_r  <= '0;
      cal_mix_r  <= '0;
      cal_hmid_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_CAL:  cal_temp_r <= cfg_wdata[47:0];
        CFG_PRESS_LO:  cal_plo_r  <= cfg_wdata;
        CFG_PRESS_HI:  cal_phi_r  <= cfg_wdata;
        CFG_MIXED_CAL: cal_mix_r  <= cfg_wdata[55:0];
        CFG_HUM_MID:   cal_hmid_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [15:0]        t1_c, p1_c;
  logic signed [15:0] t2_c, t3_c, p2_c, p3_c, p4_c, p5_c, p6_c, p7_c, p8_c, p9_c, h2_c;
  logic [7:0]         h1_c, h3_c;
  logic signed [7:0]  h6_c;
  logic signed [11:0] h4_c, h5_c;
  logic signed [31:0] t2_w, t3_w, h1_w, h2_w, h3_w, h5_w, h6_w;

  assign t1_c = cal_temp_r[15:0];
  assign t2_c = $signed(cal_temp_r[31:16]);
  assign t3_c = $signed(cal_temp_r[47:32]);
  assign p1_c = cal_plo_r[15:0];
  assign p2_c = $signed(cal_plo_r[31:16]);
  assign p3_c = $signed(cal_plo_r[47:32]);
  assign p4_c = $signed(cal_plo_r[63:48]);
  assign p5_c = $signed(cal_phi_r[15:0]);
  assign p6_c = $signed(cal_phi_r[31:16]);
  assign p7_c = $signed(cal_phi_r[47:32]);
  assign p8_c = $signed(cal_phi_r[63:48]);
  assign p9_c = $signed(cal_mix_r[15:0]);
  assign h1_c = cal_mix_r[23:16];
  assign h2_c = $signed(cal_mix_r[39:24]);
  assign h3_c = cal_mix_r[47:40];
  assign h6_c = $signed(cal_mix_r[55:48]);
  assign h4_c = $signed(cal_hmid_r[11:0]);
  assign h5_c = $signed(cal_hmid_r[23:12]);

  assign t2_w = 32'(t2_c);
  assign t3_w = 32'(t3_c);
  assign h1_w = $signed(32'(h1_c));
  assign h2_w = 32'(h2_c);
  assign h3_w = $signed(32'(h3_c));
  assign h5_w = 32'(h5_c);
  assign h6_w = 32'(h6_c);

  // ---------------- pipeline control ----------------
  logic pipe_en;
  logic skid_v_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic s7_v_r, s8_v_r, s9_v_r, s10_v_r, s11_v_r, s12_v_r;
  logic d1_v_r, d2_v_r, d3_v_r, d4_v_r;
  div_ctl_t div_in_ctl, div_out_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;  s2_v_r <= 1'b0;  s3_v_r <= 1'b0;  s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;  s6_v_r <= 1'b0;  s7_v_r <= 1'b0;  s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;  s10_v_r <= 1'b0; s11_v_r <= 1'b0; s12_v_r <= 1'b0;
      d1_v_r <= 1'b0;  d2_v_r <= 1'b0;  d3_v_r <= 1'b0;  d4_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
      d1_v_r  <= div_out_ctl.valid;
      d2_v_r  <= d1_v_r;
      d3_v_r  <= d2_v_r;
      d4_v_r  <= d3_v_r;
    end
  end

  // ---------------- stages 1..5: temperature and t_fine ----------------
  logic signed [31:0] s1_a_r, s1_b_r;
  logic [19:0]        s1_adcp_r, s2_adcp_r, s3_adcp_r, s4_adcp_r, s5_adcp_r;
  logic [19:0]        s6_adcp_r, s7_adcp_r, s8_adcp_r;
  logic [15:0]        s1_adch_r, s2_adch_r, s3_adch_r, s4_adch_r, s5_adch_r, s6_adch_r;
  logic signed [31:0] s2_v1t_r, s2_bb_r, s3_v1t_r, s3_m_r, s4_tf_r;
  logic signed [31:0] s5_temp_r, s5_hv_r;
  logic signed [32:0] s5_e_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_a_r    <= $signed(32'(in_raw_temperature >> 3) - 32'({t1_c, 1'b0}));
      s1_b_r    <= $signed(32'(in_raw_temperature >> 4) - 32'(t1_c));
      s1_adcp_r <= in_raw_pressure;
      s1_adch_r <= in_raw_humidity;

      s2_v1t_r  <= (s1_a_r * t2_w) >>> 11;
      s2_bb_r   <= s1_b_r * s1_b_r;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;

      s3_m_r    <= (s2_bb_r >>> 12) * t3_w;
      s3_v1t_r  <= s2_v1t_r;
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;

      s4_tf_r   <= s3_v1t_r + (s3_m_r >>> 14);
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;

      s5_temp_r <= (s4_tf_r * 32'sd5 + 32'sd128) >>> 8;
      s5_e_r    <= 33'(s4_tf_r) - 33'sd128000;
      s5_hv_r   <= s4_tf_r - 32'sd76800;
      s5_adcp_r <= s4_adcp_r;
      s5_adch_r <= s4_adch_r;
    end
  end

  // ---------------- stages 6..12: pressure prep and humidity ----------------
  logic signed [65:0] e2_full;
  logic signed [63:0] s6_e2_r, s7_q2a_r, s7_q1a_r, s8_q2_r, s8_q1b_r;
  logic signed [48:0] s6_e5_r, s6_e2b_r, s7_e5_r, s7_e2b_r;
  logic signed [31:0] s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r, s10_temp_r;
  logic signed [31:0] s11_temp_r, s12_temp_r;
  logic signed [31:0] s6_h5v_r, s6_vh6_r, s6_vh3_r;
  logic signed [31:0] s7_x_r, s7_y0a_r, s7_y0b_r, s8_x_r, s8_ym_r, s9_x_r, s9_y2m_r;
  logic signed [31:0] s10_vv_r, s11_vv_r, s11_ss_r, s12_vv_r, s12_ht_r;
  logic [63:0]        s9_t9_r, s9_num0_r, s10_num_r, s11_mn_r, s12_mn_r;
  logic signed [DVS_W-1:0] s10_dv_r;
  logic [DVS_W-1:0]   s11_md_r, s12_md_r;
  logic               s11_neg_r, s11_zero_r, s12_neg_r, s12_zero_r;

  assign e2_full = s5_e_r * s5_e_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // stage 6: squares and first products
      s6_e2_r   <= $signed(e2_full[63:0]);
      s6_e5_r   <= s5_e_r * p5_c;
      s6_e2b_r  <= s5_e_r * p2_c;
      s6_h5v_r  <= h5_w * s5_hv_r;
      s6_vh6_r  <= s5_hv_r * h6_w;
      s6_vh3_r  <= s5_hv_r * h3_w;
      s6_temp_r <= s5_temp_r;
      s6_adcp_r <= s5_adcp_r;
      s6_adch_r <= s5_adch_r;

      // stage 7
      s7_q2a_r  <= s6_e2_r * p6_c;
      s7_q1a_r  <= s6_e2_r * p3_c;
      s7_e5_r   <= s6_e5_r;
      s7_e2b_r  <= s6_e2b_r;
      s7_x_r    <= ($signed(32'(s6_adch_r) << 14) - (32'(h4_c) <<< 20) - s6_h5v_r
                    + 32'sd16384) >>> 15;
      s7_y0a_r  <= s6_vh6_r >>> 10;
      s7_y0b_r  <= (s6_vh3_r >>> 11) + 32'sd32768;
      s7_temp_r <= s6_temp_r;
      s7_adcp_r <= s6_adcp_r;

      // stage 8
      s8_q2_r   <= s7_q2a_r + (64'(s7_e5_r) <<< 17) + (64'(p4_c) <<< 35);
      s8_q1b_r  <= (s7_q1a_r >>> 8) + (64'(s7_e2b_r) <<< 12);
      s8_ym_r   <= s7_y0a_r * s7_y0b_r;
      s8_x_r    <= s7_x_r;
      s8_temp_r <= s7_temp_r;
      s8_adcp_r <= s7_adcp_r;

      // stage 9: divisor product and dividend base
      s9_t9_r   <= (64'h0000_8000_0000_0000 + $unsigned(s8_q1b_r)) * 64'(p1_c);
      s9_num0_r <= ((64'd1048576 - 64'(s8_adcp_r)) << 31) - $unsigned(s8_q2_r);
      s9_y2m_r  <= ((s8_ym_r >>> 10) + 32'sd2097152) * h2_w;
      s9_x_r    <= s8_x_r;
      s9_temp_r <= s8_temp_r;

      // stage 10
      s10_dv_r   <= $signed(s9_t9_r[63:33]);
      s10_num_r  <= s9_num0_r * 64'd3125;
      s10_vv_r   <= s9_x_r * ((s9_y2m_r + 32'sd8192) >>> 14);
      s10_temp_r <= s9_temp_r;

      // stage 11: magnitudes and sign for the divider
      s11_mn_r   <= s10_num_r[63] ? 64'd0 - s10_num_r : s10_num_r;
      s11_md_r   <= s10_dv_r[DVS_W-1] ? $unsigned(-s10_dv_r) : $unsigned(s10_dv_r);
      s11_neg_r  <= s10_num_r[63] ^ s10_dv_r[DVS_W-1];
      s11_zero_r <= (s10_dv_r == '0);
      s11_ss_r   <= (s10_vv_r >>> 15) * (s10_vv_r >>> 15);
      s11_vv_r   <= s10_vv_r;
      s11_temp_r <= s10_temp_r;

      // stage 12
      s12_mn_r   <= s11_mn_r;
      s12_md_r   <= s11_md_r;
      s12_neg_r  <= s11_neg_r;
      s12_zero_r <= s11_zero_r;
      s12_ht_r   <= (s11_ss_r >>> 7) * h1_w;
      s12_vv_r   <= s11_vv_r;
      s12_temp_r <= s11_temp_r;
    end
  end

  // humidity finish: subtract, clamp, scale
  logic signed [31:0] hum_diff;
  logic [31:0]        hum_clamp;
  side_t              div_in_side, div_out_side;
  logic [QUO_W-1:0]   div_out_quo;

  always_comb begin
    hum_diff = s12_vv_r - (s12_ht_r >>> 4);
    if (hum_diff[31]) begin
      hum_clamp = '0;
    end else if ($unsigned(hum_diff) > HUM_MAX) begin
      hum_clamp = HUM_MAX;
    end else begin
      hum_clamp = $unsigned(hum_diff);
    end
  end

  assign div_in_ctl.valid = s12_v_r;
  assign div_in_ctl.neg   = s12_neg_r;
  assign div_in_ctl.zero  = s12_zero_r;
  assign div_in_side.temp = s12_temp_r;
  assign div_in_side.hum  = hum_clamp[28:12];

  bthc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_ctl   (div_in_ctl),
    .in_num   (s12_mn_r),
    .in_dvs   (s12_md_r),
    .in_side  (div_in_side),
    .out_ctl  (div_out_ctl),
    .out_quo  (div_out_quo),
    .out_side (div_out_side)
  );

  // ---------------- post-division stages ----------------
  logic signed [63:0] quo_sgn;
  logic signed [63:0] d1_p_r, d1_s_r, d1_a9_r, d1_m8_r;
  logic signed [63:0] d2_p_r, d2_m8_r, d3_sum_r;
  logic [63:0]        d2_ll_r, d3_prod;
  logic [31:0]        d2_lh_r, d2_hl_r, d4_press_r;
  logic               d1_zero_r, d2_zero_r, d3_zero_r;
  side_t              d1_side_r, d2_side_r, d3_side_r, d4_side_r;
  logic signed [63:0] d4_pr;

  assign quo_sgn = div_out_ctl.neg ? $signed(64'd0 - div_out_quo) : $signed(div_out_quo);
  assign d3_prod = d2_ll_r + {d2_lh_r + d2_hl_r, 32'b0};
  assign d4_pr   = (d3_sum_r >>> 8) + (64'(p7_c) <<< 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // D1: signed quotient and first products
      d1_p_r    <= quo_sgn;
      d1_s_r    <= quo_sgn >>> 13;
      d1_a9_r   <= p9_c * (quo_sgn >>> 13);
      d1_m8_r   <= p8_c * quo_sgn;
      d1_zero_r <= div_out_ctl.zero;
      d1_side_r <= div_out_side;

      // D2: 64x64 low product as 32-bit partial products
      d2_ll_r   <= d1_a9_r[31:0] * d1_s_r[31:0];
      d2_lh_r   <= d1_a9_r[31:0] * d1_s_r[63:32];
      d2_hl_r   <= d1_a9_r[63:32] * d1_s_r[31:0];
      d2_p_r    <= d1_p_r;
      d2_m8_r   <= d1_m8_r;
      d2_zero_r <= d1_zero_r;
      d2_side_r <= d1_side_r;

      // D3: sum of correction terms
      d3_sum_r  <= d2_p_r + ($signed(d3_prod) >>> 25) + (d2_m8_r >>> 19);
      d3_zero_r <= d2_zero_r;
      d3_side_r <= d2_side_r;

      // D4: final pressure in Pa
      d4_press_r <= d3_zero_r ? '0 : d4_pr[39:8];
      d4_side_r  <= d3_side_r;
    end
  end

  // ---------------- output skid register ----------------
  logic        skid_v_nxt;
  side_t       skid_side_r;
  logic [31:0] skid_press_r;

  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r && out_ready) begin
      skid_v_nxt = 1'b0;
    end else if (pipe_en && d4_v_r && !out_ready) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && d4_v_r && !out_ready) begin
      skid_side_r  <= d4_side_r;
      skid_press_r <= d4_press_r;
    end
  end

  assign out_valid             = skid_v_r || d4_v_r;
  assign out_temperature_centi = skid_v_r ? skid_side_r.temp : d4_side_r.temp;
  assign out_humidity_q10      = skid_v_r ? skid_side_r.hum : d4_side_r.hum;
  assign out_pressure_pa       = skid_v_r ? skid_press_r : d4_press_r;

endmodule

>>> rtl/bthc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bthc_pkg for widths and the control/side structs.
module bthc_div
  import bthc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_ctl_t         in_ctl,
  input  logic [QUO_W-1:0] in_num,
  input  logic [DVS_W-1:0] in_dvs,
  input  side_t            in_side,
  output div_ctl_t         out_ctl,
  output logic [QUO_W-1:0] out_quo,
  output side_t            out_side
);

  logic             vld_r  [QUO_W];
  logic             neg_r  [QUO_W];
  logic             zero_r [QUO_W];
  logic [DVS_W-1:0] rem_r  [QUO_W];
  logic [DVS_W-1:0] dvs_r  [QUO_W];
  logic [QUO_W-1:0] nq_r   [QUO_W];
  side_t            side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in, neg_in, zero_in;
    logic [DVS_W-1:0] rem_in, dvs_in;
    logic [QUO_W-1:0] nq_in;
    side_t            side_in;
    logic [DVS_W:0]   rem2;
    logic             ge;

    if (k == 0) begin : g_head
      assign vld_in  = in_ctl.valid;
      assign neg_in  = in_ctl.neg;
      assign zero_in = in_ctl.zero;
      assign rem_in  = '0;
      assign dvs_in  = in_dvs;
      assign nq_in   = in_num;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign zero_in = zero_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign rem2 = {rem_in, nq_in[QUO_W-1]};
    assign ge   = rem2 >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    // remaining dividend bits shift out the top, quotient bits in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DVS_W'(rem2 - {1'b0, dvs_in}) : DVS_W'(rem2);
        nq_r[k]   <= {nq_in[QUO_W-2:0], ge};
        dvs_r[k]  <= dvs_in;
        neg_r[k]  <= neg_in;
        zero_r[k] <= zero_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_ctl.valid = vld_r[QUO_W-1];
  assign out_ctl.neg   = neg_r[QUO_W-1];
  assign out_ctl.zero  = zero_r[QUO_W-1];
  assign out_quo       = nq_r[QUO_W-1];
  assign out_side      = side_r[QUO_W-1];

endmodule

>>> rtl/bthc_chk.sv
// Port-level checker for the compensation core, bound to the top level.
// Depends on the shared assertion macro header.
`include "baro_temp_humidity_compensation_core_macros.svh"

module bthc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_temperature_centi,
  input logic [31:0]        out_pressure_pa,
  input logic [16:0]        out_humidity_q10
);

  // whole result payload in one vector
  logic [80:0] out_payload;

  assign out_payload = {out_temperature_centi, out_pressure_pa, out_humidity_q10};

  // a stalled result stays offered
  `BTHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `BTHC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

  // humidity never leaves the clamp range
  `BTHC_ASSERT_NOW(a_hum_range, clk, rst_n, out_valid, out_humidity_q10 <= 17'd102400)

  // input is only held off while a finished result waits
  `BTHC_ASSERT_NOW(a_backpressure, clk, rst_n, !in_ready, out_valid)

endmodule

bind baro_temp_humidity_compensation_core bthc_chk u_bthc_chk (.*);

>>> tb/sv/tb_baro_temp_humidity_compensation_core.sv
// Testbench for the compensation core: directed readings, then random bursts.
// Depends on bthc_pkg and the core; predicts each result and checks it in order.
`timescale 1ns / 100ps

module tb_baro_temp_humidity_compensation_core;
  import bthc_pkg::*;

  localparam int NUM_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic [16:0]        hum;
  } reading_t;

  // Directed stimulus row; has_exp marks rows whose result is typed in
  typedef struct {
    logic [19:0] p;
    logic [19:0] t;
    logic [15:0] h;
    bit          has_exp;
    reading_t    exp;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [19:0] in_raw_pressure, in_raw_temperature;
  logic [15:0] in_raw_humidity;
  logic signed [31:0] out_temperature_centi;
  logic [31:0] out_pressure_pa;
  logic [16:0] out_humidity_q10;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  // Shadow copy of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_plow, cal_phigh;
  logic [55:0] cal_mixed;
  logic [23:0] cal_hmid;

  reading_t expected_readings[$];
  int errors = 0;
  int cycles = 0;
  bit stall_on = 0;

  baro_temp_humidity_compensation_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  // Compensation of one raw reading with the current calibration
  function automatic reading_t compensate(logic [19:0] adc_p, logic [19:0] adc_t,
                                          logic [15:0] adc_h);
    reading_t r;
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, v1, v2, t_fine, v, x, y, s;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] q1, q2, pp, num, mn, md, qq;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'd0, cal_plow[15:0]};
    p2 = {{48{cal_plow[31]}}, cal_plow[31:16]};
    p3 = {{48{cal_plow[47]}}, cal_plow[47:32]};
    p4 = {{48{cal_plow[63]}}, cal_plow[63:48]};
    p5 = {{48{cal_phigh[15]}}, cal_phigh[15:0]};
    p6 = {{48{cal_phigh[31]}}, cal_phigh[31:16]};
    p7 = {{48{cal_phigh[47]}}, cal_phigh[47:32]};
    p8 = {{48{cal_phigh[63]}}, cal_phigh[63:48]};
    p9 = {{48{cal_mixed[15]}}, cal_mixed[15:0]};
    h1 = {24'd0, cal_mixed[23:16]};
    h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
    h3 = {24'd0, cal_mixed[47:40]};
    h6 = {{24{cal_mixed[55]}}, cal_mixed[55:48]};
    h4 = {{20{cal_hmid[11]}}, cal_hmid[11:0]};
    h5 = {{20{cal_hmid[23]}}, cal_hmid[23:12]};

    // temperature
    a = {12'd0, adc_t} >> 3;
    a = a - (t1 << 1);
    v1 = asr32(a * t2, 11);
    b = ({12'd0, adc_t} >> 4) - t1;
    v2 = asr32(asr32(b * b, 12) * t3, 14);
    t_fine = v1 + v2;
    r.temp = asr32(t_fine * 32'd5 + 32'd128, 8);

    // pressure
    q1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
    r.press = '0;
    if (q1 != 64'd0) begin
      pp = 64'd1048576 - {44'd0, adc_p};
      num = ((pp << 31) - q2) * 64'd3125;
      mn = num[63] ? -num : num;
      md = q1[63] ? -q1 : q1;
      qq = mn / md;
      pp = (num[63] != q1[63]) ? -qq : qq;
      q1 = asr64(p9 * asr64(pp, 13) * asr64(pp, 13), 25);
      q2 = asr64(p8 * pp, 19);
      pp = asr64(pp + q1 + q2, 8) + (p7 << 4);
      r.press = pp[39:8];
    end

    // humidity
    v = t_fine - 32'd76800;
    x = asr32(({16'd0, adc_h} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y = asr32(asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768), 10) + 32'd2097152;
    y = asr32(y * h2 + 32'd8192, 14);
    v = x * y;
    s = asr32(v, 15);
    v = v - asr32(asr32(s * s, 7) * h1, 4);
    if (v[31]) v = '0;
    else if (v > HUM_MAX) v = HUM_MAX;
    r.hum = v[28:12];
    return r;
  endfunction

  // Receiver stall pattern: alternating runs of ready and of random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_on <= ~stall_on;
      out_ready <= stall_on;
    end else begin
      out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = expected_readings.pop_front();
        if (out_temperature_centi !== e.temp) begin
          $display("%0t: temperature exp %0d got %0d", $time, e.temp,
                   out_temperature_centi);
          errors++;
        end
        if (out_pressure_pa !== e.press) begin
          $display("%0t: pressure exp %0d got %0d", $time, e.press, out_pressure_pa);
          errors++;
        end
        if (out_humidity_q10 !== e.hum) begin
          $display("%0t: humidity exp %0d got %0d", $time, e.hum, out_humidity_q10);
          errors++;
        end
      end
    end
  end

  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEMP_CAL:  cal_temp = data[47:0];
      CFG_PRESS_LO:  cal_plow = data;
      CFG_PRESS_HI:  cal_phigh = data;
      CFG_MIXED_CAL: cal_mixed = data[55:0];
      CFG_HUM_MID:   cal_hmid = data[23:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Typical factory calibration, or by mode all-ones, fully random, sign-edge or randomized around it
  task automatic load_cal(int mode);
    logic [63:0] r0, r1, r2, r3, r4;
    r0 = 64'({16'd50, 16'd26435, 16'd27504});
    r1 = {16'd2855, 16'hF5E8, 16'hD6D0, 16'd36477};
    r2 = {16'hFFF9, 16'h3C70, 16'hFFF9, 16'h008C};
    r3 = 64'({8'd30, 8'd0, 16'd362, 8'd75, 16'd4285});
    r4 = 64'({12'd50, 12'd312});
    if (mode == 1) begin
      r0 = 64'hFFFF_FFFF_FFFF; r1 = '1; r2 = '1; r3 = 64'hFF_FFFF_FFFF_FFFF;
      r4 = 64'hFF_FFFF;
    end else if (mode == 2) begin
      r0 = {$urandom, $urandom}; r1 = {$urandom, $urandom};
      r2 = {$urandom, $urandom}; r3 = {$urandom, $urandom};
      r4 = {$urandom, $urandom};
    end else if (mode == 3) begin
      r0 = 64'h8000_8000_0000; r1 = 64'h8000_8000_8000_FFFF;
      r2 = 64'h8000_7FFF_8000_7FFF; r3 = 64'h80_FF80_00FF_8000;
      r4 = 64'h80_0800;
    end else if (mode == 4) begin
      r0[15:0] = r0[15:0] + 16'($urandom_range(0, 2000)) - 16'd1000;
      r1[63:16] = r1[63:16] ^ 48'($urandom_range(0, 65535));
      r3[55:48] = 8'($urandom);
      r4 = 64'($urandom);
    end
    write_cal(CFG_TEMP_CAL, r0);
    write_cal(CFG_PRESS_LO, r1);
    write_cal(CFG_PRESS_HI, r2);
    write_cal(CFG_MIXED_CAL, r3);
    write_cal(CFG_HUM_MID, r4);
  endtask

  // Present one reading and hold it until accepted
  task automatic send_reading(logic [19:0] p, logic [19:0] t, logic [15:0] h);
    in_valid <= 1'b1;
    in_raw_pressure <= p;
    in_raw_temperature <= t;
    in_raw_humidity <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(compensate(p, t, h));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  stim_row_t rows[$];
  reading_t zero_reading;

  initial begin
    int gap, burst, sent, phase;
    reading_t got;
    rst_n = 0; in_valid = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_raw_pressure = '0; in_raw_temperature = '0; in_raw_humidity = '0;
    cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_mixed = '0; cal_hmid = '0;
    zero_reading = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero calibration gives zero divisor, so pressure is 0
    rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, zero_reading});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, zero_reading});
    rows.push_back('{20'h55555, 20'hAAAAA, 16'h5555, 1'b1, zero_reading});
    foreach (rows[i]) begin
      send_reading(rows[i].p, rows[i].t, rows[i].h);
      got = expected_readings[$];
      if (rows[i].has_exp && got !== rows[i].exp) begin
        $display("%0t: directed row %0d exp %h got %h", $time, i, rows[i].exp, got);
        errors++;
      end
    end
    drop_valid();
    wait_drained();

    // Directed with realistic, extreme and sign-edge calibrations
    for (int m = 0; m < 4; m++) begin
      load_cal(m == 0 ? 0 : (m == 1 ? 1 : 3));
      send_reading(20'h00000, 20'h00000, 16'h0000);
      send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_reading(20'd415148, 20'd519888, 16'd28000);
      send_reading(20'h80000, 20'h60000, 16'h8000);
      send_reading(20'd300000, 20'd400000, 16'd65000);
      drop_valid();
      wait_drained();
    end
    write_cal(CFG_IDX_UNUSED, '1);

    // Random phases: mostly realistic calibrations, some fully random
    sent = 0;
    phase = 0;
    while (sent < NUM_RANDOM) begin
      load_cal(phase % 5 == 2 ? 2 : (phase % 5 == 0 ? 0 : 4));
      for (int k = 0; k < 250 && sent < NUM_RANDOM; ) begin
        burst = $urandom_range(1, 40);
        for (int j = 0; j < burst; j++) begin
          if ($urandom_range(0, 3) == 0)
            send_reading(20'($urandom), 20'($urandom), 16'($urandom));
          else
            send_reading(20'($urandom_range(200000, 600000)),
                         20'($urandom_range(380000, 620000)),
                         16'($urandom_range(10000, 50000)));
          sent++; k++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          drop_valid();
          repeat (gap) @(posedge clk);
        end
      end
      drop_valid();
      wait_drained();
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bthc_pkg.sv
rtl/bthc_div.sv
rtl/baro_temp_humidity_compensation_core.sv
rtl/bthc_chk.sv
tb/sv/tb_baro_temp_humidity_compensation_core.sv
